// ===== rtl/hough_line_accumulator_top_macros.svh =====
// Assertion helpers for the Hough line accumulator.
`ifndef HOUGH_LINE_ACCUMULATOR_TOP_MACROS_SVH
`define HOUGH_LINE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HLA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define HLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hla_pkg;

  localparam int ANGLES      = 180;
  localparam int RHO_BINS    = 512;
  localparam int RHO_W       = $clog2(RHO_BINS);
  localparam int QUERY_BINS  = 32;
  localparam int QUERY_W     = $clog2(QUERY_BINS);
  localparam int STORE_DEPTH = ANGLES * RHO_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 15;
  localparam int FRAC_BITS   = 14;
  localparam logic [7:0] EDGE_RESET   = 8'd250;
  localparam logic [7:0] OFFSET_RESET = 8'd186;

  // Configuration register indexes
  localparam logic REG_EDGE   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  // Request kinds, same codes as the func field
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_VOTE  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  // Classified request handed from front to back
  typedef struct packed {
    func_t       kind;
    logic [6:0]  pix_x;
    logic [6:0]  pix_y;
    logic [7:0]  angle_sel;
    logic [3:0]  rho_block;
    logic [8:0]  threshold;
  } cmd_t;

  // Back-end status seen by the front and the top level
  typedef struct packed {
    logic init_busy;
    logic idle;
  } status_t;

  // Quarter-wave sine, unsigned Q1.14
  localparam logic [14:0] SIN_Q [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  function automatic logic signed [15:0] hla_sin(input logic [7:0] t);
    logic [7:0] idx;
    idx = (t <= 8'd90) ? t : 8'd180 - t;
    return $signed({1'b0, SIN_Q[idx[6:0]]});
  endfunction

  function automatic logic signed [15:0] hla_cos(input logic [7:0] t);
    logic [7:0] idx;
    if (t <= 8'd90) begin
      idx = 8'd90 - t;
      return $signed({1'b0, SIN_Q[idx[6:0]]});
    end else begin
      idx = t - 8'd90;
      return -$signed({1'b0, SIN_Q[idx[6:0]]});
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hough_line_accumulator_top.sv =====
// Hough line accumulator.
// Requests enter on s_tvalid/s_tready; s_tuser is func (0 clear, 1 vote, 2 query),
// s_tdata packs the pixel and query fields. Only queries give a result, on
// m_tvalid/m_tready, held in an output register until taken. Registers
// edge_level (index 0) and rho_offset (index 1) are written over cfg_*.
// A vote above the edge level walks all 180 angles through a four-stage
// read-modify-write pipeline on the single-port-pair vote memory, with at
// most one memory update per angle. A vote at or below the edge level is
// dropped at the input. A query reads its 32 bins one per cycle.
// A clear sweeps all 92160 entries, one per cycle. A two-entry queue
// lets new requests arrive while the back end works or waits on a
// stalled result. After reset the same clearing sweep runs and s_tready
// stays low; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "hough_line_accumulator_top_macros.svh"
module hough_line_accumulator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [6:0] pix_x, [13:7] pix_y, [21:14] gray, [29:22] angle_sel,
  // [33:30] rho_block, [42:34] threshold
  input  wire logic [47:0] s_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] hit_mask, [41:32] first_rho, [56:42] peak_votes
  output logic [63:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]       edge_level;
  logic [7:0]       rho_offset;
  logic             cmd_valid;
  logic             cmd_ready;
  hla_pkg::cmd_t    cmd;
  hla_pkg::status_t status;
  logic             cmd_take;
  logic             hit_shown;
  logic             peak_shown;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_level <= hla_pkg::EDGE_RESET;
      rho_offset <= hla_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hla_pkg::REG_EDGE:   edge_level <= cfg_data;
        hla_pkg::REG_OFFSET: rho_offset <= cfg_data;
        default:             ;
      endcase
    end
  end

  hla_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .edge_level (edge_level),
    .status     (status),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  hla_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rho_offset (rho_offset),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .status     (status)
  );

  // Checks
  assign cmd_take   = cmd_valid && cmd_ready;
  assign hit_shown  = m_tvalid && (m_tdata[31:0] != 32'd0);
  assign peak_shown = (m_tdata[56:42] != 15'd0);

  `HLA_ASSERT_IMP(a_init_blocks, clk, rst, status.init_busy, !s_tready, "taken in init sweep")
  `HLA_ASSERT_IMP(a_hit_needs_peak, clk, rst, hit_shown, peak_shown, "hit with zero peak")
  `HLA_ASSERT_NEXT(a_take_only_idle, clk, rst, cmd_take, !status.idle, "idle after a take")

endmodule
`default_nettype wire

// ===== rtl/hla_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hla_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hla_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hla_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [47:0]     s_tdata,
  input  wire logic [1:0]      s_tuser,
  input  wire logic [7:0]      edge_level,
  input  wire hla_pkg::status_t status,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output hla_pkg::cmd_t        cmd
);

  hla_pkg::cmd_t fifo [0:1];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  hla_pkg::cmd_t in_cmd;
  logic          keep;
  logic          push;
  logic          pop;

  // Unpack and classify the incoming request
  always_comb begin
    in_cmd.kind      = hla_pkg::func_t'(s_tuser);
    in_cmd.pix_x     = s_tdata[6:0];
    in_cmd.pix_y     = s_tdata[13:7];
    in_cmd.angle_sel = s_tdata[29:22];
    in_cmd.rho_block = s_tdata[33:30];
    in_cmd.threshold = s_tdata[42:34];
    case (s_tuser)
      hla_pkg::FUNC_CLEAR: keep = 1'b1;
      hla_pkg::FUNC_VOTE:  keep = (s_tdata[21:14] > edge_level);
      hla_pkg::FUNC_QUERY: keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign s_tready  = (count != 2'd2) && !status.init_busy;
  assign push      = s_tvalid && s_tready && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo[rd_ptr];

  // Two-entry queue to the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hla_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hla_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     rho_offset,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire hla_pkg::cmd_t  cmd,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [63:0]         m_tdata,
  output hla_pkg::status_t    status
);

  localparam int AW = hla_pkg::ADDR_W;
  localparam int CW = hla_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_VOTE, ST_QUERY, ST_RESULT
  } state_t;

  state_t               state;
  logic                 init_pass;
  logic [AW-1:0]        sweep_addr;
  hla_pkg::cmd_t        cur;
  logic [CW-1:0]        peak;
  logic [23:0]          limit;
  // vote pipeline
  logic [7:0]           t_cnt;
  logic                 v1, v2, v3, v4;
  logic [7:0]           t1, t2;
  logic signed [15:0]   cs1, sn1;
  logic signed [23:0]   px2, py2;
  logic [AW-1:0]        addr3, addr4;
  logic signed [25:0]   acc;
  logic                 issue;
  // query walk
  logic [hla_pkg::QUERY_W:0]   q_cnt;
  logic                        qv1;
  logic [hla_pkg::QUERY_W-1:0] qi1;
  logic [31:0]                 mask;
  logic                        q_issue;
  // memory ports
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [CW-1:0]        wr_data, rd_data, inc;

  hla_ram #(.WIDTH(CW), .DEPTH(hla_pkg::STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Bin arithmetic: floor is the arithmetic shift of the Q14 sum
  assign acc = {{2{px2[23]}}, px2} + {{2{py2[23]}}, py2}
             + $signed({4'b0, rho_offset, {hla_pkg::FRAC_BITS{1'b0}}});
  assign issue   = (state == ST_VOTE) && (t_cnt < 8'(hla_pkg::ANGLES));
  assign q_issue = (state == ST_QUERY) && !q_cnt[hla_pkg::QUERY_W];
  assign inc     = (rd_data == {CW{1'b1}}) ? rd_data : rd_data + 1'b1;

  // Memory port steering
  always_comb begin
    if (state == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else begin
      wr_en   = v4;
      wr_addr = addr4;
      wr_data = inc;
    end
    if (state == ST_QUERY) begin
      rd_en   = q_issue;
      rd_addr = AW'({cur.angle_sel, cur.rho_block, q_cnt[hla_pkg::QUERY_W-1:0]});
    end else begin
      rd_en   = v3;
      rd_addr = addr3;
    end
  end

  assign cmd_ready = (state == ST_IDLE);
  assign status    = '{init_busy: (state == ST_SWEEP) && init_pass,
                       idle:      (state == ST_IDLE)};

  // Sequencer, pipelines and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      init_pass  <= 1'b1;
      sweep_addr <= '0;
      peak       <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      qv1        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      // vote pipeline stages
      v1    <= issue;
      t1    <= t_cnt;
      cs1   <= hla_pkg::hla_cos(t_cnt);
      sn1   <= hla_pkg::hla_sin(t_cnt);
      if (issue) begin
        t_cnt <= t_cnt + 1'b1;
      end
      v2    <= v1;
      t2    <= t1;
      px2   <= $signed({1'b0, cur.pix_x}) * cs1;
      py2   <= $signed({1'b0, cur.pix_y}) * sn1;
      v3    <= v2 && !acc[25] && (acc[25:14] < 12'(hla_pkg::RHO_BINS));
      addr3 <= AW'({t2, acc[hla_pkg::FRAC_BITS +: hla_pkg::RHO_W]});
      v4    <= v3;
      addr4 <= addr3;
      if (v4 && inc > peak) begin
        peak <= inc;
      end
      // query walk
      qv1 <= q_issue;
      qi1 <= q_cnt[hla_pkg::QUERY_W-1:0];
      if (q_issue) begin
        q_cnt <= q_cnt + 1'b1;
      end
      if (qv1) begin
        mask[qi1] <= ({1'b0, rd_data, 8'b0} > {1'b0, limit});
      end

      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == AW'(hla_pkg::STORE_DEPTH - 1)) begin
            state     <= ST_IDLE;
            init_pass <= 1'b0;
            peak      <= '0;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            t_cnt <= '0;
            mask  <= '0;
            limit <= peak * cmd.threshold;
            q_cnt <= (cmd.angle_sel < 8'(hla_pkg::ANGLES)) ? '0
                     : (hla_pkg::QUERY_W+1)'(hla_pkg::QUERY_BINS);
            case (cmd.kind)
              hla_pkg::FUNC_CLEAR: begin
                state      <= ST_SWEEP;
                sweep_addr <= '0;
              end
              hla_pkg::FUNC_VOTE:  state <= ST_VOTE;
              hla_pkg::FUNC_QUERY: state <= ST_QUERY;
              default:             state <= ST_IDLE;
            endcase
          end
        end
        ST_VOTE: begin
          if (!issue && !v1 && !v2 && !v3 && !v4) begin
            state <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          if (!q_issue && !qv1) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid       <= 1'b1;
            m_tdata[31:0]  <= mask;
            m_tdata[41:32] <= {1'b0, cur.rho_block, 5'b0} - {2'b0, rho_offset};
            m_tdata[56:42] <= peak;
            m_tdata[63:57] <= '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] hit_mask;
    logic [9:0]  first_rho;
    logic [14:0] peak_votes;
  } query_result_t;

  // Mirror of the vote store; predicts query responses in request order
  class hough_scoreboard;
    bit [14:0] votes [hla_pkg::STORE_DEPTH];
    bit [14:0] peak;
    bit [7:0]  edge_lvl;
    bit [7:0]  offset;
    query_result_t awaited[$];
    int mismatches;

    function new();
      foreach (votes[i]) votes[i] = '0;
      peak = '0;
      edge_lvl = hla_pkg::EDGE_RESET;
      offset = hla_pkg::OFFSET_RESET;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] val);
      if (idx == hla_pkg::REG_EDGE) edge_lvl = val;
      else offset = val;
    endfunction

    function int q14_sin(int t);
      return (t <= 90) ? int'(hla_pkg::SIN_Q[t]) : int'(hla_pkg::SIN_Q[180 - t]);
    endfunction

    function int q14_cos(int t);
      return (t <= 90) ? int'(hla_pkg::SIN_Q[90 - t]) : -int'(hla_pkg::SIN_Q[t - 90]);
    endfunction

    function void add_votes(int x, int y);
      longint acc;
      longint bin;
      int idx;
      for (int t = 0; t < hla_pkg::ANGLES; t++) begin
        acc = longint'(x) * q14_cos(t) + longint'(y) * q14_sin(t)
            + (longint'(offset) <<< hla_pkg::FRAC_BITS);
        bin = acc >>> hla_pkg::FRAC_BITS;  // arithmetic shift gives floor
        if (bin < 0 || bin >= hla_pkg::RHO_BINS) continue;
        idx = t * hla_pkg::RHO_BINS + int'(bin);
        if (votes[idx] != 15'h7FFF) votes[idx]++;
        if (votes[idx] > peak) peak = votes[idx];
      end
    endfunction

    function void note_request(logic [1:0] f, logic [47:0] d);
      query_result_t r;
      int base;
      int ang;
      longint limit;
      case (f)
        hla_pkg::FUNC_CLEAR: begin
          foreach (votes[i]) votes[i] = '0;
          peak = '0;
        end
        hla_pkg::FUNC_VOTE: begin
          if (d[21:14] > edge_lvl) add_votes(d[6:0], d[13:7]);
        end
        hla_pkg::FUNC_QUERY: begin
          ang = d[29:22];
          base = int'(d[33:30]) * hla_pkg::QUERY_BINS;
          limit = longint'(peak) * d[42:34];
          r.hit_mask = '0;
          if (ang < hla_pkg::ANGLES)
            for (int i = 0; i < hla_pkg::QUERY_BINS; i++)
              if (base + i < hla_pkg::RHO_BINS &&
                  longint'(votes[ang * hla_pkg::RHO_BINS + base + i]) * 256 > limit)
                r.hit_mask[i] = 1'b1;
          r.first_rho = 10'(base - int'(offset));
          r.peak_votes = peak;
          awaited = {awaited, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [63:0] d);
      query_result_t exp_r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      exp_r = awaited.pop_front();
      if (d[31:0] !== exp_r.hit_mask || d[41:32] !== exp_r.first_rho ||
          d[56:42] !== exp_r.peak_votes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: mask %h/%h rho %0d/%0d peak %0d/%0d (exp/got)",
                   exp_r.hit_mask, d[31:0], $signed(exp_r.first_rho),
                   $signed(d[41:32]), exp_r.peak_votes, d[56:42]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [47:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [7:0] cfg_data;

  hough_scoreboard sb;
  bit no_idle;
  int stall;

  hough_line_accumulator_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls between accepted results
  initial begin
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
      stall = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  function automatic logic [47:0] pack_request(int x, int y, int g, int ang, int blk,
                                                int thr);
    return {5'b0, 9'(thr), 4'(blk), 8'(ang), 8'(g), 7'(y), 7'(x)};
  endfunction

  // Called just after a falling edge; returns just after a falling edge
  task automatic send_request(logic [1:0] f, logic [47:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = f;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    sb.note_request(f, d);
    @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A query behind everything else marks the back end idle once answered
  task automatic drain();
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 0, 0, 0));
    s_tvalid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_request();
    int pick, x, y, g, ang, blk, thr, slope, icpt;
    pick = $urandom_range(0, 99);
    x = $urandom_range(0, 127);
    y = $urandom_range(0, 127);
    g = $urandom_range(0, 255);
    ang = $urandom_range(0, 179);
    blk = $urandom_range(0, 15);
    thr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256);
    if (pick < 52) begin
      // points mostly on a few lines so that peaks form
      if ($urandom_range(0, 3) != 0) begin
        slope = $urandom_range(0, 2);
        icpt = 20 + 40 * $urandom_range(0, 2);
        y = (slope * x / 2 + icpt) % 128;
      end
      if (sb.edge_lvl < 255 && $urandom_range(0, 9) < 8)
        g = $urandom_range(sb.edge_lvl + 1, 255);
      send_request(hla_pkg::FUNC_VOTE, pack_request(x, y, g, ang, blk, thr));
    end else if (pick < 97) begin
      if ($urandom_range(0, 1) == 0) begin
        blk = (int'(sb.offset) + $urandom_range(0, 270) - 90);
        blk = (blk < 0) ? 0 : (blk > 511 ? 15 : blk / 32);
      end
      if ($urandom_range(0, 19) == 0) ang = $urandom_range(180, 255);
      send_request(hla_pkg::FUNC_QUERY, pack_request(x, y, g, ang, blk, thr));
    end else begin
      send_request(FUNC_UNUSED, pack_request(x, y, g, ang, blk, thr));
    end
  endtask

  initial begin
    int edges [4];
    int offs [4];
    edges = '{0, 200, 0, 100};
    offs = '{0, 255, 0, 150};
    edges[2] = $urandom_range(0, 255);
    offs[2] = $urandom_range(0, 255);
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    no_idle = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, extremes, each function
    send_request(hla_pkg::FUNC_VOTE, pack_request(127, 127, 255, 0, 0, 0));
    send_request(hla_pkg::FUNC_VOTE, pack_request(0, 0, 250, 0, 0, 0));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 45, 11, 256));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 0, 9, 0));
    drain();
    write_register(hla_pkg::REG_EDGE, 8'd255);
    write_register(hla_pkg::REG_OFFSET, 8'd255);
    send_request(hla_pkg::FUNC_VOTE, pack_request(127, 127, 255, 0, 0, 0));
    send_request(hla_pkg::FUNC_QUERY, pack_request(127, 127, 255, 255, 15, 511));
    drain();
    write_register(hla_pkg::REG_EDGE, 8'd0);
    write_register(hla_pkg::REG_OFFSET, 8'd0);
    send_request(hla_pkg::FUNC_VOTE, pack_request(127, 0, 1, 0, 0, 0));
    send_request(hla_pkg::FUNC_VOTE, pack_request(0, 127, 1, 0, 0, 0));
    send_request(hla_pkg::FUNC_VOTE, pack_request(127, 127, 0, 0, 0, 0));
    send_request(hla_pkg::FUNC_VOTE, pack_request(127, 0, 255, 0, 0, 0));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 0, 3, 256));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 90, 0, 0));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 179, 0, 128));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 180, 0, 0));
    send_request(FUNC_UNUSED, pack_request(127, 127, 255, 179, 15, 511));
    send_request(hla_pkg::FUNC_CLEAR, pack_request(0, 0, 0, 0, 0, 0));
    send_request(hla_pkg::FUNC_QUERY, pack_request(0, 0, 0, 0, 3, 0));
    drain();

    // random phases over several register settings
    for (int p = 0; p < 4; p++) begin
      write_register(hla_pkg::REG_EDGE, 8'(edges[p]));
      write_register(hla_pkg::REG_OFFSET, 8'(offs[p]));
      for (int n = 0; n < 420; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == 1 && n == 210)
          send_request(hla_pkg::FUNC_CLEAR, pack_request(0, 0, 0, 0, 0, 0));
        random_request();
      end
      no_idle = 1'b0;
      drain();
    end

    s_tvalid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
